// ===== src/erv_pkg.sv =====
// Package for the echo and reverb send chain: widths, constants, FSM state type
// and the control/status structs shared by controller and datapath.
`timescale 1ns / 1ps
package erv_pkg;
	localparam int ECHO_DEPTH_DEF = 32768;
	localparam int SAMPLE_W = 18;
	localparam int ACC_W = 24;
	localparam int CLAMP_OUT = 42598;

	localparam int LEN_A = 810;
	localparam int LEN_B = 926;
	localparam int LEN_C = 1032;
	localparam int LEN_D = 1130;
	localparam int DLEN_A = 403;
	localparam int DLEN_B = 320;
	localparam int REV_WORDS = LEN_A + LEN_B + LEN_C + LEN_D + DLEN_A + DLEN_B;
	localparam int REV_AW = $clog2(REV_WORDS);

	localparam int K_SMOOTH = 9830;
	localparam int K_COMB_Y = 24576;
	localparam int K_COMB_LP = 8192;
	localparam int K_DRIVE = 7209;
	localparam int K_ROOM_BASE = 23593;
	localparam int K_ROOM_SPAN = 8520;
	localparam int K_REV_SCALE = 19661;
	localparam int K_FB_MAX = 29491;
	localparam int K_MIX_MAX = 32768;
	localparam int K_MIX_ON = 32;

	localparam logic [2:0] REG_ECHO_MIX = 3'd0;
	localparam logic [2:0] REG_ECHO_DELAY = 3'd1;
	localparam logic [2:0] REG_ECHO_FB = 3'd2;
	localparam logic [2:0] REG_REVERB_LEVEL = 3'd3;
	localparam logic [2:0] REG_ROOM_SIZE = 3'd4;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE,
		ST_E_RD0, ST_E_RD1, ST_E_INT, ST_E_SM, ST_E_WR, ST_E_MIX,
		ST_R_DRV, ST_C_RD, ST_C_LP, ST_C_WR, ST_A_SUM, ST_D_RD, ST_D_WR,
		ST_R_MIX, ST_OUT
	} erv_state_t;

	typedef struct packed {
		logic clear_step;
		logic load_in;
		logic e_rd0;
		logic e_rd1;
		logic e_int;
		logic e_sm;
		logic e_wr;
		logic e_mix;
		logic r_drv;
		logic c_rd;
		logic c_lp;
		logic c_wr;
		logic a_sum;
		logic d_rd;
		logic d_wr;
		logic r_mix;
		logic out_load;
		logic idx_inc;
		logic idx_clr;
	} erv_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic do_echo;
		logic do_rev;
		logic comb_last;
		logic diff_last;
	} erv_stat_t;

	function automatic logic signed [47:0] sat_s(input logic signed [47:0] v,
			input int bits);
		logic signed [47:0] hi;
		logic signed [47:0] lo;
		hi = (48'sd1 <<< (bits - 1)) - 48'sd1;
		lo = -hi - 48'sd1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic logic signed [47:0] rnd_s(input logic signed [47:0] v,
			input int n);
		return (v + (48'sd1 <<< (n - 1))) >>> n;
	endfunction
endpackage

// ===== src/echo_and_reverb_send_chain_core.sv =====
// Top level of the echo and reverb send chain.
// Depends on erv_pkg, erv_ctrl and erv_datapath.
`timescale 1ns / 1ps
// One sample in, one sample out. After reset the block clears its echo and reverb
// memories, one address per cycle, max(ECHO_DEPTH, 4621) addresses in all, before
// it takes the first request. A sample with both stages off passes the idle and
// output states; echo adds states E_RD0 to E_MIX, reverb adds a drive state, four
// comb passes of read, low-pass and write, a sum state, two diffuser passes of read
// and write and a mix state, over one shared reverb memory. A stalled output stays in
// ST_OUT. Configuration must be written only while idle; the block does not check.
module echo_and_reverb_send_chain_core #(
	parameter int ECHO_DEPTH = erv_pkg::ECHO_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [22:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [17:0] sample_in,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [17:0] sample_out
);
	erv_pkg::erv_cmd_t cmd;
	erv_pkg::erv_stat_t stat;

	erv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	erv_datapath #(.ECHO_DEPTH(ECHO_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .sample_in(sample_in), .sample_out(sample_out),
		.cmd(cmd), .stat(stat)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted twice");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(sample_out)))
		else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.e_wr, cmd.c_wr, cmd.d_wr, cmd.clear_step}))
		else $error("memory write conflict");
endmodule

// ===== src/erv_ctrl.sv =====
// Sequencer for the echo and reverb send chain.
// Depends on erv_pkg; drives the datapath through erv_cmd_t.
`timescale 1ns / 1ps
module erv_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  erv_pkg::erv_stat_t stat,
	output erv_pkg::erv_cmd_t cmd
);
	erv_pkg::erv_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= erv_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			erv_pkg::ST_CLEAR: if (stat.clear_done) state_d = erv_pkg::ST_IDLE;
			erv_pkg::ST_IDLE: if (in_valid) begin
				if (stat.do_echo) state_d = erv_pkg::ST_E_RD0;
				else if (stat.do_rev) state_d = erv_pkg::ST_R_DRV;
				else state_d = erv_pkg::ST_OUT;
			end
			erv_pkg::ST_E_RD0: state_d = erv_pkg::ST_E_RD1;
			erv_pkg::ST_E_RD1: state_d = erv_pkg::ST_E_INT;
			erv_pkg::ST_E_INT: state_d = erv_pkg::ST_E_SM;
			erv_pkg::ST_E_SM: state_d = erv_pkg::ST_E_WR;
			erv_pkg::ST_E_WR: state_d = erv_pkg::ST_E_MIX;
			erv_pkg::ST_E_MIX: state_d = stat.do_rev ? erv_pkg::ST_R_DRV : erv_pkg::ST_OUT;
			erv_pkg::ST_R_DRV: state_d = erv_pkg::ST_C_RD;
			erv_pkg::ST_C_RD: state_d = erv_pkg::ST_C_LP;
			erv_pkg::ST_C_LP: state_d = erv_pkg::ST_C_WR;
			erv_pkg::ST_C_WR: state_d = stat.comb_last ? erv_pkg::ST_A_SUM : erv_pkg::ST_C_RD;
			erv_pkg::ST_A_SUM: state_d = erv_pkg::ST_D_RD;
			erv_pkg::ST_D_RD: state_d = erv_pkg::ST_D_WR;
			erv_pkg::ST_D_WR: state_d = stat.diff_last ? erv_pkg::ST_R_MIX : erv_pkg::ST_D_RD;
			erv_pkg::ST_R_MIX: state_d = erv_pkg::ST_OUT;
			erv_pkg::ST_OUT: if (out_free) state_d = erv_pkg::ST_IDLE;
			default: state_d = erv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			erv_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
			erv_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_in = in_valid;
			end
			erv_pkg::ST_E_RD0: cmd.e_rd0 = 1'b1;
			erv_pkg::ST_E_RD1: cmd.e_rd1 = 1'b1;
			erv_pkg::ST_E_INT: cmd.e_int = 1'b1;
			erv_pkg::ST_E_SM: cmd.e_sm = 1'b1;
			erv_pkg::ST_E_WR: cmd.e_wr = 1'b1;
			erv_pkg::ST_E_MIX: cmd.e_mix = 1'b1;
			erv_pkg::ST_R_DRV: begin
				cmd.r_drv = 1'b1;
				cmd.idx_clr = 1'b1;
			end
			erv_pkg::ST_C_RD: cmd.c_rd = 1'b1;
			erv_pkg::ST_C_LP: cmd.c_lp = 1'b1;
			erv_pkg::ST_C_WR: begin
				cmd.c_wr = 1'b1;
				cmd.idx_inc = !stat.comb_last;
				cmd.idx_clr = stat.comb_last;
			end
			erv_pkg::ST_A_SUM: cmd.a_sum = 1'b1;
			erv_pkg::ST_D_RD: cmd.d_rd = 1'b1;
			erv_pkg::ST_D_WR: begin
				cmd.d_wr = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			erv_pkg::ST_R_MIX: cmd.r_mix = 1'b1;
			erv_pkg::ST_OUT: cmd.out_load = out_free;
			default: ;
		endcase
	end
endmodule

// ===== src/erv_datapath.sv =====
// Datapath: configuration registers, echo line memory, reverb memory and the
// shared multiply/round/saturate arithmetic. Depends on erv_pkg.
`timescale 1ns / 1ps
module erv_datapath #(
	parameter int ECHO_DEPTH = erv_pkg::ECHO_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [22:0] cfg_data,
	input  logic signed [17:0] sample_in,
	output logic signed [17:0] sample_out,
	input  erv_pkg::erv_cmd_t cmd,
	output erv_pkg::erv_stat_t stat
);
	localparam int EAW = $clog2(ECHO_DEPTH);
	localparam int PW = EAW + 8;
	localparam logic [PW:0] SPAN = (PW+1)'(ECHO_DEPTH * 256);
	localparam int DMAX_I = (ECHO_DEPTH - 1) * 256;
	localparam logic [22:0] DMAX = 23'(DMAX_I);
	localparam int RAW = erv_pkg::REV_AW;
	localparam logic [RAW-1:0] BASE_A = '0;
	localparam logic [RAW-1:0] BASE_B = RAW'(erv_pkg::LEN_A);
	localparam logic [RAW-1:0] BASE_C = RAW'(erv_pkg::LEN_A + erv_pkg::LEN_B);
	localparam logic [RAW-1:0] BASE_D = RAW'(erv_pkg::LEN_A + erv_pkg::LEN_B
		+ erv_pkg::LEN_C);
	localparam logic [RAW-1:0] BASE_DA = RAW'(erv_pkg::LEN_A + erv_pkg::LEN_B
		+ erv_pkg::LEN_C + erv_pkg::LEN_D);
	localparam logic [RAW-1:0] BASE_DB = BASE_DA + RAW'(erv_pkg::DLEN_A);

	// configuration
	logic [15:0] echo_mix_q, reverb_level_q, room_size_q;
	logic [22:0] echo_delay_q;
	logic [14:0] echo_fb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_mix_q <= '0;
			echo_delay_q <= 23'd256;
			echo_fb_q <= '0;
			reverb_level_q <= '0;
			room_size_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				erv_pkg::REG_ECHO_MIX: echo_mix_q <= cfg_data[15:0];
				erv_pkg::REG_ECHO_DELAY: echo_delay_q <= cfg_data;
				erv_pkg::REG_ECHO_FB: echo_fb_q <= cfg_data[14:0];
				erv_pkg::REG_REVERB_LEVEL: reverb_level_q <= cfg_data[15:0];
				erv_pkg::REG_ROOM_SIZE: room_size_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [15:0] emix, rlev, room;
	logic [14:0] fb;
	logic [22:0] dly;
	assign emix = (echo_mix_q > 16'(erv_pkg::K_MIX_MAX)) ? 16'(erv_pkg::K_MIX_MAX) : echo_mix_q;
	assign rlev = (reverb_level_q > 16'(erv_pkg::K_MIX_MAX))
		? 16'(erv_pkg::K_MIX_MAX) : reverb_level_q;
	assign room = (room_size_q > 16'(erv_pkg::K_MIX_MAX))
		? 16'(erv_pkg::K_MIX_MAX) : room_size_q;
	assign fb = (echo_fb_q > 15'(erv_pkg::K_FB_MAX)) ? 15'(erv_pkg::K_FB_MAX) : echo_fb_q;
	// the upper bound can exceed the register width on deep lines
	assign dly = (echo_delay_q < 23'd256) ? 23'd256
		: ((32'(echo_delay_q) > 32'(DMAX_I)) ? DMAX : echo_delay_q);
	assign stat.do_echo = emix > 16'(erv_pkg::K_MIX_ON);
	assign stat.do_rev = rlev > 16'(erv_pkg::K_MIX_ON);

	// clearing pass over both memories
	localparam int CW = (EAW > RAW) ? EAW : RAW;
	logic [CW:0] clr_q;
	logic clr_e_done, clr_r_done;
	assign clr_e_done = clr_q >= (CW+1)'(ECHO_DEPTH);
	assign clr_r_done = clr_q >= (CW+1)'(erv_pkg::REV_WORDS);
	assign stat.clear_done = clr_e_done && clr_r_done;

	// working registers
	logic signed [17:0] x_q;
	logic signed [47:0] wet_q;
	logic [EAW-1:0] wp_q, i1_q;
	logic [7:0] frac_q;
	logic signed [17:0] s0_q, e_rd_q;
	logic signed [23:0] echo_q, smooth_q, drive_q, acc_q;
	logic [16:0] cfb_q;
	logic [30:0] rlk_q;
	logic [2:0] idx_q;
	logic [10:0] cpos_q [4];
	logic [8:0] dpos_q [2];
	logic signed [23:0] lp_q [4];
	logic signed [23:0] y_q, lpn_q, r_rd_q;
	logic signed [47:0] csum_q;
	logic signed [17:0] out_q;

	assign sample_out = out_q;
	assign stat.comb_last = idx_q == 3'd3;
	assign stat.diff_last = idx_q == 3'd1;

	// read position (combinational from delay), one guard bit for the wrap
	logic [PW:0] rp_sum;
	logic [PW-1:0] rp;
	assign rp_sum = {1'b0, wp_q, 8'd0} + SPAN - (PW+1)'(dly);
	assign rp = (rp_sum >= SPAN) ? PW'(rp_sum - SPAN) : rp_sum[PW-1:0];

	// echo memory
	logic signed [17:0] echo_mem [ECHO_DEPTH];
	logic e_we;
	logic [EAW-1:0] e_wa, e_ra;
	logic signed [17:0] e_wd;
	always_ff @(posedge clk) begin
		if (e_we) echo_mem[e_wa] <= e_wd;
		e_rd_q <= echo_mem[e_ra];
	end
	assign e_ra = cmd.e_rd0 ? rp[PW-1:8] : i1_q;

	// reverb memory, all six lines packed
	logic signed [23:0] rev_mem [erv_pkg::REV_WORDS];
	logic r_we;
	logic [RAW-1:0] r_ra, r_wa;
	logic signed [23:0] r_wd;
	always_ff @(posedge clk) begin
		if (r_we) rev_mem[r_wa] <= r_wd;
		r_rd_q <= rev_mem[r_ra];
	end

	logic [RAW-1:0] c_addr, d_addr;
	always_comb begin
		unique case (idx_q[1:0])
			2'd0: c_addr = BASE_A + RAW'(cpos_q[0]);
			2'd1: c_addr = BASE_B + RAW'(cpos_q[1]);
			2'd2: c_addr = BASE_C + RAW'(cpos_q[2]);
			default: c_addr = BASE_D + RAW'(cpos_q[3]);
		endcase
		d_addr = idx_q[0] ? BASE_DB + RAW'(dpos_q[1]) : BASE_DA + RAW'(dpos_q[0]);
	end
	assign r_ra = (cmd.d_rd || cmd.d_wr) ? d_addr : c_addr;

	// shared arithmetic terms
	logic signed [47:0] lp_new, cw_new, d_out, d_st, e_smv, e_wv;
	logic signed [63:0] rev_prod;
	assign lp_new = erv_pkg::sat_s(erv_pkg::rnd_s(48'(r_rd_q) * 48'sd24576
		+ 48'(lp_q[idx_q[1:0]]) * 48'sd8192, 15), 24);
	assign cw_new = erv_pkg::sat_s(48'(drive_q)
		+ erv_pkg::rnd_s(48'(lpn_q) * $signed({31'd0, cfb_q}), 15), 24);
	assign d_out = erv_pkg::sat_s(48'(r_rd_q) - 48'(acc_q), 24);
	assign d_st = erv_pkg::sat_s(48'(acc_q) + (48'(r_rd_q) >>> 1), 24);
	assign e_smv = erv_pkg::sat_s(48'(smooth_q) + erv_pkg::rnd_s((48'(echo_q)
		- 48'(smooth_q)) * 48'sd9830, 15), 24);
	assign e_wv = erv_pkg::sat_s(48'(x_q)
		+ erv_pkg::rnd_s(48'(smooth_q) * $signed({33'd0, fb}), 15), 18);
	assign rev_prod = 64'(acc_q) * $signed({33'd0, rlk_q}) + (64'sd1 <<< 29);

	always_comb begin
		e_we = 1'b0;
		e_wa = wp_q;
		e_wd = e_wv[17:0];
		r_we = 1'b0;
		r_wa = c_addr;
		r_wd = cw_new[23:0];
		if (cmd.clear_step) begin
			e_we = !clr_e_done;
			e_wa = clr_q[EAW-1:0];
			e_wd = '0;
			r_we = !clr_r_done;
			r_wa = clr_q[RAW-1:0];
			r_wd = '0;
		end else if (cmd.e_wr) begin
			e_we = 1'b1;
		end else if (cmd.c_wr) begin
			r_we = 1'b1;
		end else if (cmd.d_wr) begin
			r_we = 1'b1;
			r_wa = d_addr;
			r_wd = d_st[23:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			wp_q <= '0;
			smooth_q <= '0;
			idx_q <= '0;
			for (int k = 0; k < 4; k++) begin
				cpos_q[k] <= '0;
				lp_q[k] <= '0;
			end
			dpos_q[0] <= '0;
			dpos_q[1] <= '0;
		end else begin
			if (cmd.clear_step && !stat.clear_done) clr_q <= clr_q + 1'b1;
			if (cmd.e_sm) smooth_q <= e_smv[23:0];
			if (cmd.e_wr) wp_q <= (wp_q == EAW'(ECHO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (cmd.c_lp) lp_q[idx_q[1:0]] <= lp_new[23:0];
			if (cmd.c_wr) begin
				unique case (idx_q[1:0])
					2'd0: cpos_q[0] <= (cpos_q[0] == 11'(erv_pkg::LEN_A - 1)) ? '0 : cpos_q[0] + 1'b1;
					2'd1: cpos_q[1] <= (cpos_q[1] == 11'(erv_pkg::LEN_B - 1)) ? '0 : cpos_q[1] + 1'b1;
					2'd2: cpos_q[2] <= (cpos_q[2] == 11'(erv_pkg::LEN_C - 1)) ? '0 : cpos_q[2] + 1'b1;
					default: cpos_q[3] <= (cpos_q[3] == 11'(erv_pkg::LEN_D - 1)) ? '0
						: cpos_q[3] + 1'b1;
				endcase
			end
			if (cmd.d_wr) begin
				if (idx_q[0])
					dpos_q[1] <= (dpos_q[1] == 9'(erv_pkg::DLEN_B - 1)) ? '0 : dpos_q[1] + 1'b1;
				else
					dpos_q[0] <= (dpos_q[0] == 9'(erv_pkg::DLEN_A - 1)) ? '0 : dpos_q[0] + 1'b1;
			end
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q <= sample_in;
			wet_q <= 48'(sample_in);
			csum_q <= '0;
		end
		if (cmd.e_rd0) begin
			i1_q <= (rp[PW-1:8] == EAW'(ECHO_DEPTH - 1)) ? '0 : rp[PW-1:8] + 1'b1;
			frac_q <= rp[7:0];
		end
		if (cmd.e_rd1) s0_q <= e_rd_q;
		if (cmd.e_int) echo_q <= 24'(48'(s0_q)
			+ ((48'(e_rd_q) - 48'(s0_q)) * $signed({40'd0, frac_q}) >>> 8));
		if (cmd.e_mix) wet_q <= wet_q
			+ erv_pkg::rnd_s(48'(echo_q) * $signed({32'd0, emix}), 15);
		if (cmd.r_drv) begin
			drive_q <= 24'(erv_pkg::sat_s(erv_pkg::rnd_s(wet_q * 48'sd7209, 15), 24));
			cfb_q <= 17'(48'sd23593 + erv_pkg::rnd_s($signed({32'd0, room}) * 48'sd8520, 15));
			rlk_q <= 31'(rlev) * 31'(erv_pkg::K_REV_SCALE);
			csum_q <= '0;
		end
		if (cmd.c_lp) begin
			lpn_q <= lp_new[23:0];
			y_q <= r_rd_q;
		end
		if (cmd.c_wr) csum_q <= csum_q + 48'(y_q);
		if (cmd.a_sum) acc_q <= 24'(erv_pkg::sat_s(csum_q, 24));
		if (cmd.d_wr) acc_q <= d_out[23:0];
		if (cmd.r_mix) wet_q <= wet_q + 48'(rev_prod >>> 30);
		if (cmd.out_load) begin
			if (!stat.do_echo && !stat.do_rev) out_q <= x_q;
			else if (wet_q > 48'sd42598) out_q <= 18'sd42598;
			else if (wet_q < -48'sd42598) out_q <= -18'sd42598;
			else out_q <= wet_q[17:0];
		end
	end
endmodule

// ===== tb/erv_checker.sv =====
// Checker for the echo and reverb send chain: tracks register writes, predicts
// every output sample from the accepted input samples and compares. Uses erv_pkg.
`timescale 1ns / 1ps
module erv_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [22:0] cfg_data,
	input  logic in_valid,
	input  logic in_ready,
	input  logic signed [17:0] sample_in,
	input  logic out_valid,
	input  logic out_ready,
	input  logic signed [17:0] sample_out,
	output int fail_count,
	output int pending
);
	import erv_pkg::*;

	localparam int DEPTH = ECHO_DEPTH_DEF;
	localparam int COMB_LEN[4] = '{LEN_A, LEN_B, LEN_C, LEN_D};
	localparam int DIFF_LEN[2] = '{DLEN_A, DLEN_B};

	logic [15:0] mix_reg;
	logic [22:0] delay_reg;
	logic [14:0] fb_reg;
	logic [15:0] level_reg;
	logic [15:0] room_reg;

	int echo_mem[DEPTH];
	int echo_pos;
	longint echo_lp;
	int comb_mem[4][LEN_D];
	int comb_pos[4];
	longint comb_lp[4];
	int diff_mem[2][DLEN_A];
	int diff_pos[2];

	logic signed [17:0] expected_q[$];

	function automatic longint clamp_bits(input longint v, input int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic longint round_shift(input longint v, input int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	// Advance the echo and reverb state by one sample, return the output sample.
	function automatic logic signed [17:0] process_sample(input logic signed [17:0] din);
		longint x, wet, dmax, d, fb, span, rp, frac, s0, s1, tap, sm;
		longint emix, rlev, room, cfb, drive, acc, y, lp, bo, o;
		int i0, i1, p, c;
		x = din;
		emix = (mix_reg > K_MIX_MAX) ? K_MIX_MAX : mix_reg;
		rlev = (level_reg > K_MIX_MAX) ? K_MIX_MAX : level_reg;
		if (emix <= K_MIX_ON && rlev <= K_MIX_ON)
			return din;
		wet = x;
		if (emix > K_MIX_ON) begin
			dmax = longint'(DEPTH - 1) * 256;
			d = delay_reg;
			if (d < 256)
				d = 256;
			else if (d > dmax)
				d = dmax;
			fb = (fb_reg > K_FB_MAX) ? K_FB_MAX : fb_reg;
			span = longint'(DEPTH) * 256;
			rp = (longint'(echo_pos) * 256 + span - d) % span;
			i0 = int'(rp >> 8);
			i1 = (i0 + 1) % DEPTH;
			frac = rp & 255;
			s0 = echo_mem[i0];
			s1 = echo_mem[i1];
			tap = s0 + (((s1 - s0) * frac) >>> 8);
			sm = clamp_bits(echo_lp + round_shift((tap - echo_lp) * K_SMOOTH, 15), 24);
			echo_lp = sm;
			echo_mem[echo_pos] = int'(clamp_bits(x + round_shift(sm * fb, 15), 18));
			echo_pos = (echo_pos + 1) % DEPTH;
			wet += round_shift(tap * emix, 15);
		end
		if (rlev > K_MIX_ON) begin
			room = (room_reg > K_MIX_MAX) ? K_MIX_MAX : room_reg;
			cfb = K_ROOM_BASE + round_shift(K_ROOM_SPAN * room, 15);
			drive = clamp_bits(round_shift(wet * K_DRIVE, 15), 24);
			acc = 0;
			for (c = 0; c < 4; c++) begin
				p = comb_pos[c];
				y = comb_mem[c][p];
				lp = clamp_bits(round_shift(y * K_COMB_Y + comb_lp[c] * K_COMB_LP, 15), 24);
				comb_lp[c] = lp;
				comb_mem[c][p] = int'(clamp_bits(drive + round_shift(lp * cfb, 15), 24));
				comb_pos[c] = (p + 1) % COMB_LEN[c];
				acc += y;
			end
			acc = clamp_bits(acc, 24);
			for (c = 0; c < 2; c++) begin
				p = diff_pos[c];
				bo = diff_mem[c][p];
				o = clamp_bits(bo - acc, 24);
				diff_mem[c][p] = int'(clamp_bits(acc + (bo >>> 1), 24));
				diff_pos[c] = (p + 1) % DIFF_LEN[c];
				acc = o;
			end
			wet += round_shift(acc * rlev * K_REV_SCALE, 30);
		end
		if (wet > CLAMP_OUT)
			wet = CLAMP_OUT;
		else if (wet < -CLAMP_OUT)
			wet = -CLAMP_OUT;
		return wet[17:0];
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic signed [17:0] want;
		if (!arst_n) begin
			mix_reg = '0;
			delay_reg = 23'd256;
			fb_reg = '0;
			level_reg = '0;
			room_reg = '0;
			foreach (echo_mem[i]) echo_mem[i] = 0;
			foreach (comb_mem[i, j]) comb_mem[i][j] = 0;
			foreach (diff_mem[i, j]) diff_mem[i][j] = 0;
			foreach (comb_pos[i]) begin
				comb_pos[i] = 0;
				comb_lp[i] = 0;
			end
			diff_pos = '{0, 0};
			echo_pos = 0;
			echo_lp = 0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected output sample %0d", sample_out);
				end else begin
					want = expected_q.pop_front();
					if (sample_out !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("sample_out mismatch: expected %0d, got %0d",
								want, sample_out);
					end
				end
			end
			if (in_valid && in_ready)
				expected_q.push_back(process_sample(sample_in));
			if (cfg_we) begin
				case (cfg_index)
					REG_ECHO_MIX: mix_reg = cfg_data[15:0];
					REG_ECHO_DELAY: delay_reg = cfg_data;
					REG_ECHO_FB: fb_reg = cfg_data[14:0];
					REG_REVERB_LEVEL: level_reg = cfg_data[15:0];
					REG_ROOM_SIZE: room_reg = cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== tb/echo_and_reverb_send_chain_core_tb.sv =====
// Testbench top for the echo and reverb send chain: drives samples, register
// writes and output stalls; erv_checker does the prediction. Uses erv_pkg.
`timescale 1ns / 1ps
module echo_and_reverb_send_chain_core_tb;
	import erv_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 48;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [22:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [17:0] sample_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [17:0] sample_out;
	int fail_count;
	int pending;
	int cycles = 0;
	int hold_off = 0;
	bit steady = 1'b0;

	echo_and_reverb_send_chain_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
		.out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out)
	);

	erv_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
		.out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always begin
		@(negedge clk);
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off--;
		end else begin
			out_ready <= steady || ($urandom_range(99) >= 32);
		end
	end

	task automatic send_sample(input logic signed [17:0] value);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		sample_in <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic go_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [22:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic set_chain(input logic [22:0] mix, input logic [22:0] delay,
			input logic [22:0] fb, input logic [22:0] level, input logic [22:0] room);
		write_reg(REG_ECHO_MIX, mix);
		write_reg(REG_ECHO_DELAY, delay);
		write_reg(REG_ECHO_FB, fb);
		write_reg(REG_REVERB_LEVEL, level);
		write_reg(REG_ROOM_SIZE, room);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [17:0] pick_sample();
		case ($urandom_range(5))
			0: return 18'sh1FFFF;
			1: return -18'sh20000;
			2: return 18'sd0;
			3: return $signed(18'($urandom_range(4095))) - 18'sd2048;
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic logic [22:0] pick_mix();
		case ($urandom_range(6))
			0: return 23'd0;
			1: return 23'd32;
			2: return 23'd33;
			3: return 23'd32768;
			4: return 23'($urandom);
			default: return 23'($urandom_range(32768));
		endcase
	endfunction

	function automatic logic [22:0] pick_delay();
		case ($urandom_range(7))
			0: return 23'($urandom_range(255));
			1: return 23'h7FFFFF;
			2: return 23'($urandom);
			default: return 23'($urandom_range(256, 150 * 256));
		endcase
	endfunction

	task automatic run_phase(input int count);
		repeat (count) send_sample(pick_sample());
		go_quiet();
		wait_drained();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Both stages off: samples pass through.
		send_sample(18'sh1FFFF);
		send_sample(-18'sh20000);
		send_sample(-18'sd1);
		send_sample(18'sd1);
		go_quiet();
		wait_drained();

		// Echo only; mix, delay and feedback past their limits.
		set_chain(23'h7FFFFF, 23'd0, 23'h7FFF, 23'd0, 23'd0);
		send_sample(18'sh1FFFF);
		send_sample(-18'sh20000);
		send_sample(18'sh1FFFF);
		send_sample(18'sd0);
		send_sample(18'sd12345);
		go_quiet();
		wait_drained();

		// Longest delay, clamped to a whole-sample position.
		set_chain(23'd32768, 23'h7FFFFF, 23'd29491, 23'd0, 23'd0);
		send_sample(18'sh1FFFF);
		send_sample(-18'sh20000);
		go_quiet();
		wait_drained();

		// Reverb only, room and level past one; ignored register indexes.
		set_chain(23'd32, 23'd300, 23'd100, 23'hFFFF, 23'hFFFF);
		write_reg(3'd5, 23'h7FFFFF);
		write_reg(3'd6, 23'h0);
		write_reg(3'd7, 23'h5555);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_sample(18'sh1FFFF);
		send_sample(-18'sh20000);
		send_sample(18'sh1FFFF);
		send_sample(18'sd0);
		go_quiet();
		wait_drained();

		// Both on, smallest settings that still enable.
		set_chain(23'd33, 23'd257, 23'd0, 23'd33, 23'd0);
		send_sample(18'sh1FFFF);
		send_sample(-18'sh20000);
		send_sample(18'sd77);
		send_sample(18'sd0);
		go_quiet();
		wait_drained();

		// Random settings; one phase without idling, one with a long output stall.
		for (int ph = 0; ph < 10; ph++) begin
			set_chain(pick_mix(), pick_delay(), 23'($urandom_range(32767)),
				pick_mix(), pick_mix());
			steady = (ph == 3);
			if (ph == 5)
				hold_off = 300;
			run_phase(84);
		end
		steady = 1'b0;

		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
